### sv/ispfp_pkg.sv
`default_nettype none
package ispfp_pkg;
  localparam int PAGE_BYTES_DEF = 128;
  localparam int MEMORY_BYTES_DEF = 32768;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT, PH_ENABLE, PH_SIG, PH_ERASE, PH_POLL_ERASE,
    PH_FILL, PH_LOAD, PH_WRITE, PH_POLL_WRITE, PH_READ
  } phase_t;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_IMAGE = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ID     = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_VERIFY = 2'd3;

  localparam logic [1:0] CFG_ID    = 2'd0;
  localparam logic [1:0] CFG_WAIT  = 2'd1;
  localparam logic [1:0] CFG_SIZE  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       read_fail;
  } req_t;

  typedef struct packed {
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       want_page;
    logic       reset_released;
    logic       select_active;
    logic       done_res;
    logic [1:0] status;
  } res_t;
endpackage
`default_nettype wire

### sv/ispfp_if.sv
`default_nettype none
interface ispfp_req_if;
  logic valid;
  logic ready;
  ispfp_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ispfp_res_if;
  logic valid;
  logic ready;
  ispfp_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/ispfp_page_ram.sv
`default_nettype none
module ispfp_page_ram #(
  parameter int DEPTH = ispfp_pkg::PAGE_BYTES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/isp_flash_programmer_sequencer.sv
// ISP flash programmer sequencer.
// The req channel carries start, image byte, SPI response and millisecond
// tick words; the res channel returns exactly one word for each accepted
// req word, carrying the byte to shift out, the page request pulse, the
// target reset and select levels, and the done pulse with its status.
// Configuration registers (expected id, reset wait, image size) are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while the
// sequencer is idle, as the block itself does not enforce it.
// A result word passes the stage-one request register and the output queue
// before it is offered on res. The page buffer is a one-port-read memory;
// the load byte needed by the next command is prefetched at the edge that
// commits the previous step, so the memory read overlaps the wait for the
// response and the result is built from the registered request.
// Throughput: one word per cycle when res is not stalled.
// A two-entry output queue with a credit count keeps the pipeline moving;
// req.ready drops only when the queue and the pipeline could overflow it.
// Reset (rst, synchronous) returns to idle with target released and select
// deselected; the page buffer contents are left as they are.
`default_nettype none
module isp_flash_programmer_sequencer #(
  parameter int PAGE_BYTES = ispfp_pkg::PAGE_BYTES_DEF,
  parameter int MEMORY_BYTES = ispfp_pkg::MEMORY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  ispfp_req_if.sink        req,
  ispfp_res_if.source      res
);
  localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int KW = $clog2(PAGE_BYTES + 1);
  localparam logic [16:0] PB = 17'(PAGE_BYTES);
  localparam logic [16:0] MB = 17'(MEMORY_BYTES > 65535 ? 65535 : MEMORY_BYTES);
  localparam logic [1:0] CFG_ID_SEL = ispfp_pkg::CFG_ID;
  localparam logic [1:0] CFG_WAIT_SEL = ispfp_pkg::CFG_WAIT;
  localparam logic [1:0] CFG_SIZE_SEL = ispfp_pkg::CFG_SIZE;

  logic [23:0] exp_id;
  logic [7:0]  wait_ticks;
  logic [15:0] img_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_id <= 24'h1E950F;
      wait_ticks <= 8'd20;
      img_size <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_SEL:   exp_id <= cfg_data;
        CFG_WAIT_SEL: wait_ticks <= cfg_data[7:0];
        CFG_SIZE_SEL: img_size <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Output queue with credit control.
  ispfp_pkg::res_t q [2];
  logic [1:0] q_cnt;
  logic       q_rd;
  logic [1:0] inflight;
  logic       s1_valid;
  ispfp_pkg::req_t s1_req;
  logic       s2_push;
  ispfp_pkg::res_t s2_res;

  assign inflight = 2'(q_cnt) + {1'b0, s1_valid};
  assign req.ready = (inflight < 2'd2) || (inflight == 2'd2 && q_rd);
  assign res.valid = q_cnt != 2'd0;
  assign res.data = q[0];
  assign q_rd = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt + 2'(s2_push) - 2'(q_rd);
    end
    if (q_rd) begin
      if (s2_push && q_cnt == 2'd1) q[0] <= s2_res;
      else q[0] <= q[1];
      if (s2_push && q_cnt == 2'd2) q[1] <= s2_res;
    end else if (s2_push) begin
      if (q_cnt == 2'd0) q[0] <= s2_res;
      else q[1] <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= req.valid && req.ready;
    s1_req <= req.data;
  end
  assign s2_push = s1_valid;

  // Sequencer state; the step is computed in stage two, the page memory is
  // read at the end of the previous step so its data is ready here.
  ispfp_pkg::phase_t phase, phase_next;
  logic [1:0]  cbc, cbc_next;
  logic [7:0]  wcnt, wcnt_next;
  logic [23:0] idacc, idacc_next;
  logic [16:0] pbase, pbase_next;
  logic [KW-1:0] kpos, kpos_next;
  logic [31:0] wsum, wsum_next, rsum, rsum_next;
  logic        blank, blank_next, rlev, rlev_next, slev, slev_next;

  logic        m_we, m_re;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]  m_rdata;

  ispfp_page_ram #(.DEPTH(PAGE_BYTES)) u_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(s1_req.data_byte),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  logic [16:0] lim;
  logic [16:0] plen;
  logic [16:0] rem;
  assign lim = ({1'b0, img_size} > MB) ? MB : {1'b0, img_size};
  assign rem = lim - pbase;
  assign plen = (pbase >= lim) ? 17'd0 : ((rem < PB) ? rem : PB);

  // Command byte for phase p, count c, position k with current page base.
  function automatic logic [7:0] cmd(input ispfp_pkg::phase_t p, input logic [1:0] c,
                                     input logic [KW-1:0] k, input logic [16:0] base,
                                     input logic [16:0] len, input logic [7:0] mb);
    logic [15:0] wa;
    logic [15:0] a;
    logic [16:0] kk;
    logic [7:0] r;
    wa = base[16:1];
    kk = 17'(k);
    a = wa + kk[16:1];
    r = 8'h00;
    unique case (p)
      ispfp_pkg::PH_ENABLE: r = (c == 2'd0) ? 8'hAC : ((c == 2'd1) ? 8'h53 : 8'h00);
      ispfp_pkg::PH_SIG:    r = (c == 2'd0) ? 8'h30 : ((c == 2'd2) ? kk[7:0] : 8'h00);
      ispfp_pkg::PH_ERASE:  r = (c == 2'd0) ? 8'hAC : ((c == 2'd1) ? 8'h80 : 8'h00);
      ispfp_pkg::PH_POLL_ERASE, ispfp_pkg::PH_POLL_WRITE:
        r = (c == 2'd0) ? 8'hF0 : 8'h00;
      ispfp_pkg::PH_LOAD: begin
        if (c == 2'd0) r = kk[0] ? 8'h48 : 8'h40;
        else if (c == 2'd2) r = kk[8:1];
        else if (c == 2'd3) r = (kk < len) ? mb : 8'hFF;
      end
      ispfp_pkg::PH_WRITE: begin
        if (c == 2'd0) r = 8'h4C;
        else if (c == 2'd1) r = wa[15:8];
        else if (c == 2'd2) r = wa[7:0];
      end
      ispfp_pkg::PH_READ: begin
        if (c == 2'd0) r = kk[0] ? 8'h28 : 8'h20;
        else if (c == 2'd1) r = a[15:8];
        else if (c == 2'd2) r = a[7:0];
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [7:0] b;
  logic [16:0] kx, plen_even;
  logic [16:0] nbase;
  assign b = s1_req.data_byte;
  assign kx = 17'(kpos) + 17'd1;
  assign plen_even = (plen + 17'd1) & ~17'd1;
  assign nbase = pbase + PB;

  logic       o_valid, o_want, o_done;
  logic [7:0] o_byte;
  logic [1:0] o_status;
  logic [31:0] sh;

  always_comb begin
    phase_next = phase; cbc_next = cbc; wcnt_next = wcnt; idacc_next = idacc;
    pbase_next = pbase; kpos_next = kpos; wsum_next = wsum; rsum_next = rsum;
    blank_next = blank; rlev_next = rlev; slev_next = slev;
    o_valid = 1'b0; o_byte = 8'h00; o_want = 1'b0; o_done = 1'b0;
    o_status = ispfp_pkg::ST_OK;
    m_we = 1'b0; m_waddr = kpos[AW-1:0];
    sh = 32'({24'd0, b}) << {kpos[1:0], 3'b000};
    if (s1_valid) begin
      if (s1_req.req_type == ispfp_pkg::REQ_START && phase == ispfp_pkg::PH_IDLE) begin
        slev_next = 1'b1; rlev_next = 1'b0; wcnt_next = 8'd0;
        if (wait_ticks == 8'd0) begin
          phase_next = ispfp_pkg::PH_ENABLE; cbc_next = 2'd0; o_valid = 1'b1;
          o_byte = 8'hAC;
        end else phase_next = ispfp_pkg::PH_WAIT;
      end else if (s1_req.req_type == ispfp_pkg::REQ_TICK &&
                   phase == ispfp_pkg::PH_WAIT) begin
        wcnt_next = (wcnt == 8'hFF) ? wcnt : wcnt + 8'd1;
        if (wcnt_next >= wait_ticks) begin
          phase_next = ispfp_pkg::PH_ENABLE; cbc_next = 2'd0; o_valid = 1'b1;
          o_byte = 8'hAC;
        end
      end else if (s1_req.req_type == ispfp_pkg::REQ_IMAGE &&
                   phase == ispfp_pkg::PH_FILL) begin
        if (s1_req.read_fail) begin
          rlev_next = 1'b1; slev_next = 1'b0; phase_next = ispfp_pkg::PH_IDLE;
          o_done = 1'b1; o_status = ispfp_pkg::ST_READ;
        end else begin
          m_we = kx <= PB;
          wsum_next = wsum ^ sh;
          blank_next = blank && (b == 8'hFF);
          kpos_next = KW'(kx);
          if (kx >= plen) begin
            if (blank_next) begin
              pbase_next = nbase;
              if (nbase >= lim) begin
                rlev_next = 1'b1; slev_next = 1'b0; phase_next = ispfp_pkg::PH_IDLE;
                o_done = 1'b1;
              end else begin
                slev_next = 1'b0; o_want = 1'b1; kpos_next = '0;
                wsum_next = '0; rsum_next = '0; blank_next = 1'b1;
              end
            end else begin
              slev_next = 1'b1; kpos_next = '0; phase_next = ispfp_pkg::PH_LOAD;
              cbc_next = 2'd0; o_valid = 1'b1; o_byte = 8'h40;
            end
          end
        end
      end else if (s1_req.req_type == ispfp_pkg::REQ_RESP &&
                   phase != ispfp_pkg::PH_IDLE && phase != ispfp_pkg::PH_WAIT &&
                   phase != ispfp_pkg::PH_FILL) begin
        if (cbc != 2'd3) begin
          cbc_next = cbc + 2'd1; o_valid = 1'b1;
          o_byte = cmd(phase, cbc_next, kpos, pbase, plen, m_rdata);
        end else begin
          cbc_next = 2'd0; o_valid = 1'b1;
          unique case (phase)
            ispfp_pkg::PH_ENABLE: begin
              kpos_next = '0; idacc_next = '0; phase_next = ispfp_pkg::PH_SIG;
            end
            ispfp_pkg::PH_SIG: begin
              idacc_next = {idacc[15:0], b};
              kpos_next = KW'(kx);
              if (kx < 17'd3) phase_next = ispfp_pkg::PH_SIG;
              else if (idacc_next == exp_id) phase_next = ispfp_pkg::PH_ERASE;
              else begin
                o_valid = 1'b0; rlev_next = 1'b1; slev_next = 1'b0;
                phase_next = ispfp_pkg::PH_IDLE; o_done = 1'b1;
                o_status = ispfp_pkg::ST_ID;
              end
            end
            ispfp_pkg::PH_ERASE: phase_next = ispfp_pkg::PH_POLL_ERASE;
            ispfp_pkg::PH_POLL_ERASE: begin
              if (!b[0]) begin
                o_valid = 1'b0; pbase_next = '0;
                if (lim == 17'd0) begin
                  rlev_next = 1'b1; slev_next = 1'b0; phase_next = ispfp_pkg::PH_IDLE;
                  o_done = 1'b1;
                end else begin
                  slev_next = 1'b0; o_want = 1'b1; phase_next = ispfp_pkg::PH_FILL;
                  kpos_next = '0; wsum_next = '0; rsum_next = '0; blank_next = 1'b1;
                end
              end
            end
            ispfp_pkg::PH_LOAD: begin
              kpos_next = KW'(kx);
              phase_next = (kx < plen_even) ? ispfp_pkg::PH_LOAD : ispfp_pkg::PH_WRITE;
            end
            ispfp_pkg::PH_WRITE: phase_next = ispfp_pkg::PH_POLL_WRITE;
            ispfp_pkg::PH_POLL_WRITE: begin
              if (!b[0]) begin
                kpos_next = '0; rsum_next = '0; phase_next = ispfp_pkg::PH_READ;
              end
            end
            ispfp_pkg::PH_READ: begin
              rsum_next = rsum ^ sh;
              kpos_next = KW'(kx);
              if (kx < plen) phase_next = ispfp_pkg::PH_READ;
              else begin
                o_valid = 1'b0;
                if (rsum_next == wsum) begin
                  pbase_next = nbase;
                  if (nbase >= lim) begin
                    rlev_next = 1'b1; slev_next = 1'b0;
                    phase_next = ispfp_pkg::PH_IDLE; o_done = 1'b1;
                  end else begin
                    slev_next = 1'b0; o_want = 1'b1; phase_next = ispfp_pkg::PH_FILL;
                    kpos_next = '0; wsum_next = '0; rsum_next = '0; blank_next = 1'b1;
                  end
                end else begin
                  rlev_next = 1'b1; slev_next = 1'b0; phase_next = ispfp_pkg::PH_IDLE;
                  o_done = 1'b1; o_status = ispfp_pkg::ST_VERIFY;
                end
              end
            end
            default: o_valid = 1'b0;
          endcase
          if (o_valid) o_byte = cmd(phase_next, 2'd0, kpos_next, pbase, plen, 8'h00);
        end
      end
    end
  end

  // Prefetch the byte at the next position; only the load data byte uses it
  // and the position is stable across the four bytes of a command.
  assign m_re = 1'b1;
  assign m_raddr = kpos_next[AW-1:0];

  assign s2_res = '{spi_valid: o_valid, spi_byte: o_byte, want_page: o_want,
                    reset_released: rlev_next, select_active: slev_next,
                    done_res: o_done, status: o_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ispfp_pkg::PH_IDLE; cbc <= '0; wcnt <= '0; idacc <= '0;
      pbase <= '0; kpos <= '0; wsum <= '0; rsum <= '0; blank <= 1'b1;
      rlev <= 1'b1; slev <= 1'b0;
    end else begin
      phase <= phase_next; cbc <= cbc_next; wcnt <= wcnt_next; idacc <= idacc_next;
      pbase <= pbase_next; kpos <= kpos_next; wsum <= wsum_next; rsum <= rsum_next;
      blank <= blank_next; rlev <= rlev_next; slev <= slev_next;
    end
  end
endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none

class isp_scoreboard;
  bit [23:0] exp_id;
  bit [7:0]  wait_ticks;
  bit [15:0] img_size;
  ispfp_pkg::phase_t ph;
  bit [2:0]  cbc;
  bit [7:0]  wcnt;
  bit [23:0] id_acc;
  bit [16:0] base;
  bit [7:0]  store [ispfp_pkg::PAGE_BYTES_DEF];
  bit [8:0]  pos;
  bit [31:0] wsum, rsum;
  bit        blank, rst_lvl, sel_lvl;
  ispfp_pkg::res_t cur;
  ispfp_pkg::res_t pending [$];
  int        errors;

  function new();
    exp_id = 24'h1E950F;
    wait_ticks = 8'd20;
    img_size = 16'd0;
    ph = ispfp_pkg::PH_IDLE;
    cbc = 0;
    wcnt = 0;
    id_acc = 0;
    base = 0;
    pos = 0;
    wsum = 0;
    rsum = 0;
    blank = 1;
    rst_lvl = 1;
    sel_lvl = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      ispfp_pkg::CFG_ID: exp_id = val;
      ispfp_pkg::CFG_WAIT: wait_ticks = val[7:0];
      ispfp_pkg::CFG_SIZE: img_size = val[15:0];
      default: ;
    endcase
  endfunction

  function int limit_bytes();
    return (img_size > ispfp_pkg::MEMORY_BYTES_DEF) ? ispfp_pkg::MEMORY_BYTES_DEF
                                                    : int'(img_size);
  endfunction

  function int page_len();
    int r;
    if (base >= limit_bytes()) return 0;
    r = limit_bytes() - base;
    return (r < ispfp_pkg::PAGE_BYTES_DEF) ? r : ispfp_pkg::PAGE_BYTES_DEF;
  endfunction

  function bit [7:0] cmd_byte();
    bit [15:0] wa, a;
    wa = base[16:1];
    a = wa + 16'(pos[8:1]);
    case (ph)
      ispfp_pkg::PH_ENABLE: return cbc == 0 ? 8'hAC : (cbc == 1 ? 8'h53 : 8'h00);
      ispfp_pkg::PH_SIG: return cbc == 0 ? 8'h30 : (cbc == 2 ? pos[7:0] : 8'h00);
      ispfp_pkg::PH_ERASE: return cbc == 0 ? 8'hAC : (cbc == 1 ? 8'h80 : 8'h00);
      ispfp_pkg::PH_POLL_ERASE, ispfp_pkg::PH_POLL_WRITE:
        return cbc == 0 ? 8'hF0 : 8'h00;
      ispfp_pkg::PH_LOAD: begin
        if (cbc == 0) return pos[0] ? 8'h48 : 8'h40;
        if (cbc == 2) return pos[8:1];
        if (cbc == 3) return (pos < page_len()) ? store[pos] : 8'hFF;
        return 8'h00;
      end
      ispfp_pkg::PH_WRITE: begin
        if (cbc == 0) return 8'h4C;
        if (cbc == 1) return wa[15:8];
        if (cbc == 2) return wa[7:0];
        return 8'h00;
      end
      ispfp_pkg::PH_READ: begin
        if (cbc == 0) return pos[0] ? 8'h28 : 8'h20;
        if (cbc == 1) return a[15:8];
        if (cbc == 2) return a[7:0];
        return 8'h00;
      end
      default: return 8'h00;
    endcase
  endfunction

  function void start_cmd(ispfp_pkg::phase_t p);
    ph = p;
    cbc = 0;
    cur.spi_valid = 1;
    cur.spi_byte = cmd_byte();
  endfunction

  function void finish(logic [1:0] st);
    rst_lvl = 1;
    sel_lvl = 0;
    ph = ispfp_pkg::PH_IDLE;
    cur.done_res = 1;
    cur.status = st;
  endfunction

  function void begin_page();
    if (base >= limit_bytes()) begin
      finish(ispfp_pkg::ST_OK);
      return;
    end
    sel_lvl = 0;
    cur.want_page = 1;
    ph = ispfp_pkg::PH_FILL;
    pos = 0;
    wsum = 0;
    rsum = 0;
    blank = 1;
  endfunction

  function void on_image(bit [7:0] b, bit fail);
    if (fail) begin
      finish(ispfp_pkg::ST_READ);
      return;
    end
    store[pos] = b;
    wsum ^= 32'(b) << (8 * pos[1:0]);
    if (b != 8'hFF) blank = 0;
    pos++;
    if (pos >= page_len()) begin
      if (blank) begin
        base = base + 17'(ispfp_pkg::PAGE_BYTES_DEF);
        begin_page();
      end else begin
        sel_lvl = 1;
        pos = 0;
        start_cmd(ispfp_pkg::PH_LOAD);
      end
    end
  endfunction

  function void on_response(bit [7:0] b);
    if (cbc < 3) begin
      cbc++;
      cur.spi_valid = 1;
      cur.spi_byte = cmd_byte();
      return;
    end
    case (ph)
      ispfp_pkg::PH_ENABLE: begin
        pos = 0;
        id_acc = 0;
        start_cmd(ispfp_pkg::PH_SIG);
      end
      ispfp_pkg::PH_SIG: begin
        id_acc = {id_acc[15:0], b};
        pos++;
        if (pos < 3) start_cmd(ispfp_pkg::PH_SIG);
        else if (id_acc == exp_id) start_cmd(ispfp_pkg::PH_ERASE);
        else finish(ispfp_pkg::ST_ID);
      end
      ispfp_pkg::PH_ERASE: start_cmd(ispfp_pkg::PH_POLL_ERASE);
      ispfp_pkg::PH_POLL_ERASE: begin
        if (b[0]) start_cmd(ispfp_pkg::PH_POLL_ERASE);
        else begin
          base = 0;
          begin_page();
        end
      end
      ispfp_pkg::PH_LOAD: begin
        pos++;
        if (pos < ((page_len() + 1) & ~1)) start_cmd(ispfp_pkg::PH_LOAD);
        else start_cmd(ispfp_pkg::PH_WRITE);
      end
      ispfp_pkg::PH_WRITE: start_cmd(ispfp_pkg::PH_POLL_WRITE);
      ispfp_pkg::PH_POLL_WRITE: begin
        if (b[0]) start_cmd(ispfp_pkg::PH_POLL_WRITE);
        else begin
          pos = 0;
          rsum = 0;
          start_cmd(ispfp_pkg::PH_READ);
        end
      end
      ispfp_pkg::PH_READ: begin
        rsum ^= 32'(b) << (8 * pos[1:0]);
        pos++;
        if (pos < page_len()) start_cmd(ispfp_pkg::PH_READ);
        else if (rsum == wsum) begin
          base = base + 17'(ispfp_pkg::PAGE_BYTES_DEF);
          begin_page();
        end else finish(ispfp_pkg::ST_VERIFY);
      end
      default: ;
    endcase
  endfunction

  function void note_request(ispfp_pkg::req_t w);
    cur = '0;
    if (w.req_type == ispfp_pkg::REQ_START && ph == ispfp_pkg::PH_IDLE) begin
      sel_lvl = 1;
      rst_lvl = 0;
      wcnt = 0;
      if (wait_ticks == 0) start_cmd(ispfp_pkg::PH_ENABLE);
      else ph = ispfp_pkg::PH_WAIT;
    end else if (w.req_type == ispfp_pkg::REQ_TICK && ph == ispfp_pkg::PH_WAIT) begin
      if (wcnt < 255) wcnt++;
      if (wcnt >= wait_ticks) start_cmd(ispfp_pkg::PH_ENABLE);
    end else if (w.req_type == ispfp_pkg::REQ_IMAGE && ph == ispfp_pkg::PH_FILL) begin
      on_image(w.data_byte, w.read_fail);
    end else if (w.req_type == ispfp_pkg::REQ_RESP && ph >= ispfp_pkg::PH_ENABLE &&
                 ph != ispfp_pkg::PH_FILL) begin
      on_response(w.data_byte);
    end
    cur.reset_released = rst_lvl;
    cur.select_active = sel_lvl;
    pending.push_back(cur);
  endfunction

  function void compare(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endfunction

  function void check_result(ispfp_pkg::res_t r);
    ispfp_pkg::res_t e;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    compare("spi_valid", e.spi_valid, r.spi_valid);
    compare("spi_byte", e.spi_byte, r.spi_byte);
    compare("want_page", e.want_page, r.want_page);
    compare("reset_released", e.reset_released, r.reset_released);
    compare("select_active", e.select_active, r.select_active);
    compare("done_res", e.done_res, r.done_res);
    compare("status", e.status, r.status);
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1650;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = ispfp_pkg::CFG_ID;
  logic [23:0] cfg_data = '0;
  int          cycles = 0;
  int          sent = 0;
  bit          tx_gaps = 1;
  bit          rx_stalls = 1;
  bit          big_run = 0;
  bit          fail_first = 0;
  bit          blank_page = 0;
  int          stall_left = 0;
  isp_scoreboard sb = new();

  ispfp_req_if req_ch();
  ispfp_res_if res_ch();

  isp_flash_programmer_sequencer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .res(res_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    res_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // Receiver stalls: mostly short, now and then long.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready = 0;
      stall_left--;
    end else begin
      res_ch.ready = 1;
      if (rx_stalls && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  task automatic send(ispfp_pkg::req_t w);
    req_ch.data = w;
    req_ch.valid = 1;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(w);
    sent++;
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_we = 1;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Mostly the word the sequencer is waiting for, with plausible content.
  function automatic ispfp_pkg::req_t next_word();
    ispfp_pkg::req_t w;
    w = '0;
    if ($urandom_range(0, 24) == 0) begin
      w.req_type = 2'($urandom_range(0, 3));
      w.data_byte = 8'($urandom_range(0, 255));
      w.read_fail = ($urandom_range(0, 15) == 0);
      return w;
    end
    w.data_byte = 8'($urandom_range(0, 255));
    case (sb.ph)
      ispfp_pkg::PH_IDLE: w.req_type = ispfp_pkg::REQ_START;
      ispfp_pkg::PH_WAIT: w.req_type = ispfp_pkg::REQ_TICK;
      ispfp_pkg::PH_FILL: begin
        w.req_type = ispfp_pkg::REQ_IMAGE;
        if (sb.pos == 9'd0)
          blank_page = big_run ? (sb.base < 17'd256) : ($urandom_range(0, 3) == 0);
        if (blank_page || $urandom_range(0, 15) == 0) w.data_byte = 8'hFF;
        w.read_fail = fail_first || ($urandom_range(0, 499) == 0);
      end
      ispfp_pkg::PH_SIG: begin
        w.req_type = ispfp_pkg::REQ_RESP;
        if (sb.cbc == 3 && $urandom_range(0, 29) != 0)
          w.data_byte = 8'(sb.exp_id >> (8 * (2 - sb.pos)));
      end
      ispfp_pkg::PH_POLL_ERASE, ispfp_pkg::PH_POLL_WRITE: begin
        w.req_type = ispfp_pkg::REQ_RESP;
        if (sb.cbc == 3) w.data_byte[0] = ($urandom_range(0, 3) == 0);
      end
      ispfp_pkg::PH_READ: begin
        w.req_type = ispfp_pkg::REQ_RESP;
        if (sb.cbc == 3 && $urandom_range(0, 39) != 0) w.data_byte = sb.store[sb.pos];
      end
      default: w.req_type = ispfp_pkg::REQ_RESP;
    endcase
    return w;
  endfunction

  task automatic run_sequence();
    bit started;
    started = 0;
    while (!started || sb.ph != ispfp_pkg::PH_IDLE) begin
      send(next_word());
      if (sb.ph != ispfp_pkg::PH_IDLE) started = 1;
    end
  endtask

  task automatic configure(logic [23:0] id, logic [7:0] wt, logic [15:0] sz);
    drain();
    write_reg(ispfp_pkg::CFG_ID, id);
    write_reg(ispfp_pkg::CFG_WAIT, wt);
    write_reg(ispfp_pkg::CFG_SIZE, sz);
  endtask

  initial begin
    int cfg_no;
    ispfp_pkg::req_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Words that idle ignores, then a short odd-length image with no reset wait.
    w = '0;
    w.req_type = ispfp_pkg::REQ_RESP;
    send(w);
    w.req_type = ispfp_pkg::REQ_TICK;
    send(w);
    w.req_type = ispfp_pkg::REQ_IMAGE;
    w.read_fail = 1;
    w.data_byte = 8'hFF;
    send(w);
    configure(24'h1E950F, 8'd0, 16'd3);
    run_sequence();
    configure(24'hFFFFFF, 8'd255, 16'd0);
    run_sequence();
    configure(24'h000000, 8'd1, 16'd1);
    run_sequence();

    // Two blank pages are skipped, then a short page at a nonzero base.
    big_run = 1;
    tx_gaps = 0;
    configure(24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 8)), 16'd259);
    run_sequence();
    big_run = 0;
    tx_gaps = 1;

    // Oversized image that the source cannot supply.
    fail_first = 1;
    configure(24'($urandom_range(0, 24'hFFFFFF)), 8'd2, 16'hFFFF);
    run_sequence();
    fail_first = 0;

    cfg_no = 0;
    while (sent < ITEM_TARGET) begin
      tx_gaps = (cfg_no % 3) != 1;
      rx_stalls = (cfg_no % 4) != 2;
      configure(24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 6)),
                ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24)));
      run_sequence();
      if (sb.pending.size() != 0 && $urandom_range(0, 1) == 0) begin
        // Hold the sender until every outstanding word has come back.
        req_ch.valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      run_sequence();
      cfg_no++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
